// ----- design/pbwl_pkg.sv -----
// Package for the packed bit word list store.
// Holds the transaction payload types, action and status codes, and the cell control struct.
// No dependencies.
`default_nettype none

package pbwl_pkg;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_READ   = 3'd2;
    localparam logic [2:0] ACT_WRITE  = 3'd3;
    localparam logic [2:0] ACT_MODIFY = 3'd4;
    localparam logic [2:0] ACT_FLIP   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] position;
        logic [7:0] word_value;
        logic [3:0] flag_index;
        logic       flag_value;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [6:0] entry_count;
        logic [1:0] status;
    } rsp_t;

    // Broadcast to every cell in the execute cycle
    typedef struct packed {
        logic ins_en;
        logic del_en;
        logic wr_en;
        logic mod_en;
        logic rd_en;
        logic flip_en;
        logic flag_value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/pbwl_stream_if.sv -----
// Valid/ready channel interface for the packed bit word list store.
// The payload type is set at instantiation; see pbwl_pkg for the types used.
`default_nettype none

interface pbwl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/pbwl_cell.sv -----
// One word cell of the store chain.
// Holds one word, takes a neighbor's word on insert/delete shifts. Uses pbwl_pkg.
`default_nettype none

module pbwl_cell #(
    parameter int WORD_BITS = 8,
    parameter int IDX       = 0,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7,
    parameter int BIT_W     = 3
) (
    input  wire logic                    clk,
    input  wire pbwl_pkg::cell_ctl_t     ctl,
    input  wire logic [IDX_W-1:0]        slot,
    input  wire logic [CNT_W-1:0]        count,
    input  wire logic [BIT_W-1:0]        bit_pos,
    input  wire logic [WORD_BITS-1:0]    word_in,
    input  wire logic [WORD_BITS-1:0]    left_word,
    input  wire logic [WORD_BITS-1:0]    right_word,
    output logic      [WORD_BITS-1:0]    word,
    output logic      [WORD_BITS-1:0]    hit_word
);
    import pbwl_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [WORD_BITS-1:0] flag_mask;
    logic                 at_slot;
    logic                 below_count;
    logic                 within_count;
    logic                 has_right;

    assign at_slot      = (slot == IDX_W'(IDX));
    assign below_count  = (CNT_W'(IDX) < count);
    assign within_count = (CNT_W'(IDX) <= count);
    assign has_right    = (CNT_W'(IDX + 1) < count);
    assign flag_mask    = WORD_BITS'(1) << bit_pos;

    always_comb
    begin
        word_next = word_reg;
        priority if (ctl.ins_en)
        begin
            if (at_slot)
                word_next = word_in;
            else if ((IDX_W'(IDX) > slot) && within_count)
                word_next = left_word;
        end
        else if (ctl.del_en)
        begin
            if ((IDX_W'(IDX) >= slot) && has_right)
                word_next = right_word;
        end
        else if (ctl.wr_en)
        begin
            if (at_slot)
                word_next = word_in;
        end
        else if (ctl.mod_en)
        begin
            if (at_slot)
                word_next = ctl.flag_value ? (word_reg | flag_mask) : (word_reg & ~flag_mask);
        end
        else if (ctl.flip_en)
        begin
            if (below_count)
                word_next = ~word_reg;
        end
        else
        begin
            // idle or read: word holds
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign hit_word = ((ctl.rd_en || ctl.wr_en || ctl.mod_en) && at_slot) ? word_next : '0;

endmodule

`default_nettype wire

// ----- design/packed_bit_word_list_store_core.sv -----
// Top level of the packed bit word list store: command register, decode, cell chain
// and result register. Uses pbwl_pkg, pbwl_stream_if and pbwl_cell.
`default_nettype none

// An ordered list of up to DEPTH words of WORD_BITS flags each, kept in a chain of word
// cells, with a stored count. Each request transaction carries one operation (insert,
// delete, read, write, modify one flag, flip all) and yields exactly one response
// transaction with the data, the new count and a status. A request is registered on
// accept; when it executes (the output register is empty or being read), all cells
// update together (shifting words to or from their neighbors for insert and delete)
// and the response is loaded into the output register. One transaction per cycle is
// sustained while the response side keeps ready high, set by the single execute
// stage of the cell chain. Bad positions, bad flag indexes and inserts into a full
// store are reported in status and leave the store untouched. Stored words come up
// undefined after reset; only the first entry_count positions are ever read.
module packed_bit_word_list_store_core #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    pbwl_stream_if.sink        req,
    pbwl_stream_if.source      rsp
);
    import pbwl_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int BIT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [6:0] WB = 7'(WORD_BITS);

    // Command stage
    req_t             cmd_reg;
    logic             cmd_valid_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Response stage
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;

    logic             exec;
    logic             req_fire;

    // Decode
    cell_ctl_t             ctl;
    logic [IDX_W-1:0]      slot;
    logic [BIT_W-1:0]      bit_pos;
    logic [WORD_BITS-1:0]  word_in;
    logic [CMP_W-1:0]      pos_w;
    logic [CMP_W-1:0]      cnt_w;
    logic [IDX_W-1:0]      tgt_idx;
    logic                  pos_ok;
    logic                  flag_ok;
    logic                  full;
    logic [1:0]            status;

    // Cell chain
    logic [WORD_BITS-1:0]  cell_word [DEPTH];
    logic [WORD_BITS-1:0]  cell_hit  [DEPTH];
    logic [WORD_BITS-1:0]  hit_or;

    assign exec     = cmd_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !cmd_valid_reg || exec;
    assign req_fire = req.valid && req.ready;

    assign pos_w   = CMP_W'(cmd_reg.position);
    assign cnt_w   = CMP_W'(count_reg);
    assign pos_ok  = (pos_w != '0) && (pos_w <= cnt_w);
    assign flag_ok = (cmd_reg.flag_index != 4'd0) && ({3'b000, cmd_reg.flag_index} <= WB);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign tgt_idx = IDX_W'(pos_w - CMP_W'(1));
    assign bit_pos = BIT_W'(WB - {3'b000, cmd_reg.flag_index});
    assign word_in = WORD_BITS'(cmd_reg.word_value);

    // Operation decode; the target is the 1-based position less one, except that
    // insert moves it to the front or to the append slot
    always_comb
    begin
        ctl            = '0;
        ctl.flag_value = cmd_reg.flag_value;
        slot           = tgt_idx;
        status         = ST_OK;
        count_next     = count_reg;
        unique case (cmd_reg.action)
            ACT_INSERT:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    ctl.ins_en = exec;
                    count_next = count_reg + CNT_W'(1);
                    if ((count_reg == '0) || (pos_w <= CMP_W'(1)))
                        slot = '0;
                    else if (pos_w > cnt_w)
                        slot = IDX_W'(count_reg);
                end
            end
            ACT_DELETE:
            begin
                if (!pos_ok)
                    status = ST_BAD_POS;
                else
                begin
                    ctl.del_en = exec;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_READ:
            begin
                if (!pos_ok)
                    status = ST_BAD_POS;
                else
                    ctl.rd_en = exec;
            end
            ACT_WRITE:
            begin
                if (!pos_ok)
                    status = ST_BAD_POS;
                else
                    ctl.wr_en = exec;
            end
            ACT_MODIFY:
            begin
                if (!pos_ok || !flag_ok)
                    status = ST_BAD_POS;
                else
                    ctl.mod_en = exec;
            end
            ACT_FLIP:
            begin
                ctl.flip_en = exec;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Word cells; each passes its word both ways along the chain
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;

        if (g == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_left
            assign left_word = cell_word[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_right
            assign right_word = cell_word[g+1];
        end

        pbwl_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX       (g),
            .IDX_W     (IDX_W),
            .CNT_W     (CNT_W),
            .BIT_W     (BIT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .slot       (slot),
            .count      (count_reg),
            .bit_pos    (bit_pos),
            .word_in    (word_in),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (cell_word[g]),
            .hit_word   (cell_hit[g])
        );
    end

    // At most one cell reports a hit; others drive zero
    always_comb
    begin
        hit_or = '0;
        for (int i = 0; i < DEPTH; i++)
            hit_or = hit_or | cell_hit[i];
    end

    always_comb
    begin
        rsp_next.read_data   = 8'(hit_or);
        rsp_next.entry_count = 7'(count_next);
        rsp_next.status      = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (req_fire)
                cmd_valid_reg <= 1'b1;
            else if (exec)
                cmd_valid_reg <= 1'b0;

            if (exec)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;

            if (exec)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            cmd_reg <= req.payload;
        if (exec)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stored count exceeds depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        exec && (cmd_reg.action == ACT_INSERT) && !full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted insert did not grow the count");

    a_fail_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status != ST_OK) |-> rsp_reg.read_data == 8'd0)
        else $error("failed transaction carries data");

    a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && !exec |=> cmd_valid_reg && $stable(cmd_reg))
        else $error("pending command lost before execute");
`endif

endmodule

`default_nettype wire
